>>> hdl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, off while reset is low
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> hdl/vav_pkg.sv
// shared constants, latencies and tables of the axis-angle rotation pipeline
package vav_pkg;

  // word format
  localparam int unsigned WordW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned QBits    = 30;

  localparam logic signed [WordW-1:0] WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] WordMin = {1'b1, {(WordW-1){1'b0}}};

  // angle reduction: theta widened to Q61, reduced modulo 2*pi in Q61
  localparam logic [63:0] TwoPiQ61  = 64'hC90FDAA22168C235;
  localparam int unsigned RedShift  = 61 - FracBits;
  localparam int unsigned RedW      = WordW + RedShift;
  localparam int unsigned RedSteps  = RedW - 63;

  // angle and cordic datapath
  localparam int unsigned AngW      = 34;
  localparam int unsigned CordIters = 30;
  localparam logic signed [AngW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [AngW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;

  // pipeline depths
  localparam int unsigned SqrtLat = 2 + WordW;
  localparam int unsigned DivLat  = QBits + 1;
  localparam int unsigned TrigLat = RedSteps + 2 + CordIters;
  localparam int unsigned RodLat  = 6;

  // atan(2^-idx) in q30, exact to the lsb
  function automatic logic signed [AngW-1:0] atan_q30(input int unsigned idx);
    logic signed [AngW-1:0] val;
    unique case (idx)
      0: val = 34'sd843314857;
      1: val = 34'sd497837829;
      2: val = 34'sd263043837;
      3: val = 34'sd133525159;
      4: val = 34'sd67021687;
      5: val = 34'sd33543516;
      6: val = 34'sd16775851;
      7: val = 34'sd8388437;
      8: val = 34'sd4194283;
      9: val = 34'sd2097149;
      default: val = AngW'(64'd1 << (QBits - idx));
    endcase
    return val;
  endfunction

endpackage

>>> hdl/axis_angle_vector_rotate.sv
// top level of the axis-angle vector rotation pipeline
//
//   beat      handshake                    payload
//   input     in_valid_i / in_stall_o      vec_x/y/z_i, axis_x/y/z_i
//   output    out_valid_o / out_stall_i    rot_x/y/z_o, clipped_o
//
// one beat per cycle while the output beat is not held; the squares and square root come first,
// then the 2*pi reduction and 30-stage cordic (the 31-stage divider runs alongside),
// and last the combine.
// reset clears only the valid bits of the pipeline.
// a stalled output beat freezes every stage, so in_stall_o follows it.
module axis_angle_vector_rotate (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [vav_pkg::WordW-1:0]  vec_x_i,
  input  logic signed [vav_pkg::WordW-1:0]  vec_y_i,
  input  logic signed [vav_pkg::WordW-1:0]  vec_z_i,
  input  logic signed [vav_pkg::WordW-1:0]  axis_x_i,
  input  logic signed [vav_pkg::WordW-1:0]  axis_y_i,
  input  logic signed [vav_pkg::WordW-1:0]  axis_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [vav_pkg::WordW-1:0]  rot_x_o,
  output logic signed [vav_pkg::WordW-1:0]  rot_y_o,
  output logic signed [vav_pkg::WordW-1:0]  rot_z_o,
  output logic                              clipped_o
);
  localparam int unsigned WordW   = vav_pkg::WordW;
  localparam int unsigned AngW    = vav_pkg::AngW;
  localparam int unsigned SqrtLat = vav_pkg::SqrtLat;
  localparam int unsigned TrigLat = vav_pkg::TrigLat;
  localparam int unsigned VecDly  = SqrtLat + TrigLat;
  localparam int unsigned UnitDly = TrigLat - vav_pkg::DivLat;
  localparam int unsigned TotLat  = SqrtLat + TrigLat + vav_pkg::RodLat;

  logic                    adv;
  logic                    valid_q [TotLat];
  logic signed [WordW-1:0] ax_q [SqrtLat][3];
  logic signed [WordW-1:0] vec_q [VecDly][3];
  logic signed [WordW-1:0] unit_q [UnitDly][3];
  logic                    zero_q [TrigLat];
  logic [WordW-1:0]        theta;
  logic signed [WordW-1:0] unit [3];
  logic signed [AngW-1:0]  sin_v, cos_v;
  logic signed [WordW-1:0] rot [3];

  // whole pipe moves unless the output beat is held
  assign adv         = !(valid_q[TotLat-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = valid_q[TotLat-1];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '{default: 1'b0};
    end else if (adv) begin
      valid_q[0] <= in_valid_i;
      for (int s = 1; s < TotLat; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  // payload delay lines
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q[0][0] <= axis_x_i;
      ax_q[0][1] <= axis_y_i;
      ax_q[0][2] <= axis_z_i;
      for (int s = 1; s < SqrtLat; s++) begin
        ax_q[s] <= ax_q[s-1];
      end
      vec_q[0][0] <= vec_x_i;
      vec_q[0][1] <= vec_y_i;
      vec_q[0][2] <= vec_z_i;
      for (int s = 1; s < VecDly; s++) begin
        vec_q[s] <= vec_q[s-1];
      end
      unit_q[0] <= unit;
      for (int s = 1; s < UnitDly; s++) begin
        unit_q[s] <= unit_q[s-1];
      end
      zero_q[0] <= (theta == '0);
      for (int s = 1; s < TrigLat; s++) begin
        zero_q[s] <= zero_q[s-1];
      end
    end
  end

  vav_sqrt u_sqrt (
    .clk_i    (clk_i),
    .en_i     (adv),
    .axis_x_i (axis_x_i),
    .axis_y_i (axis_y_i),
    .axis_z_i (axis_z_i),
    .theta_o  (theta)
  );

  // one divider lane per axis component
  for (genvar i = 0; i < 3; i++) begin : g_div
    vav_div u_div (
      .clk_i   (clk_i),
      .en_i    (adv),
      .axis_i  (ax_q[SqrtLat-1][i]),
      .theta_i (theta),
      .unit_o  (unit[i])
    );
  end

  vav_sincos u_sincos (
    .clk_i   (clk_i),
    .en_i    (adv),
    .theta_i (theta),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  vav_rodrigues u_rodrigues (
    .clk_i     (clk_i),
    .en_i      (adv),
    .vec_i     (vec_q[VecDly-1]),
    .unit_i    (unit_q[UnitDly-1]),
    .sin_i     (sin_v),
    .cos_i     (cos_v),
    .zero_i    (zero_q[TrigLat-1]),
    .rot_o     (rot),
    .clipped_o (clipped_o)
  );

  assign rot_x_o = rot[0];
  assign rot_y_o = rot[1];
  assign rot_z_o = rot[2];

endmodule

>>> hdl/vav_sqrt.sv
// sum of squares and one-bit-per-stage integer square root of the axis length
module vav_sqrt (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [vav_pkg::WordW-1:0]   axis_x_i,
  input  logic signed [vav_pkg::WordW-1:0]   axis_y_i,
  input  logic signed [vav_pkg::WordW-1:0]   axis_z_i,
  output logic        [vav_pkg::WordW-1:0]   theta_o
);
  localparam int unsigned WordW = vav_pkg::WordW;
  localparam int unsigned SumW  = 2 * WordW;
  localparam int unsigned RemW  = WordW + 3;

  logic [WordW-1:0] mag [3];
  logic [SumW-1:0]  sq_d [3];
  logic [SumW-1:0]  sq_q [3];
  logic [SumW-1:0]  sum_d, sum_q;
  logic [SumW-1:0]  rad_d [WordW];
  logic [SumW-1:0]  rad_q [WordW];
  logic [RemW-1:0]  rem_d [WordW];
  logic [RemW-1:0]  rem_q [WordW];
  logic [WordW-1:0] root_d [WordW];
  logic [WordW-1:0] root_q [WordW];

  // magnitudes and squares
  always_comb begin
    mag[0] = $unsigned(axis_x_i[WordW-1] ? -axis_x_i : axis_x_i);
    mag[1] = $unsigned(axis_y_i[WordW-1] ? -axis_y_i : axis_y_i);
    mag[2] = $unsigned(axis_z_i[WordW-1] ? -axis_z_i : axis_z_i);
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = SumW'(mag[i]) * SumW'(mag[i]);
    end
    sum_d = sq_q[0] + sq_q[1] + sq_q[2];
  end

  // one root bit per stage
  always_comb begin
    logic [SumW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RemW-1:0]  rsh;
    logic [RemW-1:0]  trial;
    logic [WordW-1:0] root;
    logic             take;
    for (int k = 0; k < WordW; k++) begin
      if (k == 0) begin
        rad  = sum_q;
        rem  = '0;
        root = '0;
      end else begin
        rad  = rad_q[k-1];
        rem  = rem_q[k-1];
        root = root_q[k-1];
      end
      rsh       = {rem[RemW-3:0], rad[SumW-1 -: 2]};
      trial     = {1'b0, root, 2'b01};
      take      = rsh >= trial;
      rem_d[k]  = take ? rsh - trial : rsh;
      root_d[k] = {root[WordW-2:0], take};
      rad_d[k]  = rad << 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_d;
      sum_q <= sum_d;
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign theta_o = root_q[WordW-1];

endmodule

>>> hdl/vav_div.sv
// restoring divider lane: unit axis component |a| * 2^30 / theta, one bit per stage
module vav_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [vav_pkg::WordW-1:0]  axis_i,
  input  logic        [vav_pkg::WordW-1:0]  theta_i,
  output logic signed [vav_pkg::WordW-1:0]  unit_o
);
  localparam int unsigned WordW = vav_pkg::WordW;
  localparam int unsigned QBits = vav_pkg::QBits;
  localparam int unsigned Steps = vav_pkg::DivLat;
  localparam int unsigned RemW  = WordW + QBits + 1;

  logic [WordW-1:0] mag;
  logic [RemW-1:0]  rem_d [Steps];
  logic [RemW-1:0]  rem_q [Steps];
  logic [QBits:0]   quo_d [Steps];
  logic [QBits:0]   quo_q [Steps];
  logic [WordW-1:0] den_d [Steps];
  logic [WordW-1:0] den_q [Steps];
  logic             neg_d [Steps];
  logic             neg_q [Steps];

  assign mag = $unsigned(axis_i[WordW-1] ? -axis_i : axis_i);

  // quotient bit per stage, msb first
  always_comb begin
    logic [RemW-1:0]  rem;
    logic [RemW-1:0]  dsh;
    logic [QBits:0]   quo;
    logic [WordW-1:0] den;
    logic             neg;
    logic             take;
    for (int k = 0; k < Steps; k++) begin
      if (k == 0) begin
        rem = RemW'(mag) << QBits;
        quo = '0;
        den = theta_i;
        neg = axis_i[WordW-1];
      end else begin
        rem = rem_q[k-1];
        quo = quo_q[k-1];
        den = den_q[k-1];
        neg = neg_q[k-1];
      end
      dsh      = RemW'(den) << (Steps - 1 - k);
      take     = rem >= dsh;
      rem_d[k] = take ? rem - dsh : rem;
      quo_d[k] = {quo[QBits-1:0], take};
      den_d[k] = den;
      neg_d[k] = neg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_d;
      neg_q <= neg_d;
    end
  end

  // restore the sign
  assign unit_o = neg_q[Steps-1] ? -$signed(WordW'(quo_q[Steps-1]))
                                 : $signed(WordW'(quo_q[Steps-1]));

endmodule

>>> hdl/vav_sincos.sv
// angle reduction modulo 2*pi and pipelined cordic for sine and cosine in q30
module vav_sincos (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic        [vav_pkg::WordW-1:0]  theta_i,
  output logic signed [vav_pkg::AngW-1:0]   sin_o,
  output logic signed [vav_pkg::AngW-1:0]   cos_o
);
  localparam int unsigned RedW     = vav_pkg::RedW;
  localparam int unsigned RedSteps = vav_pkg::RedSteps;
  localparam int unsigned AngW     = vav_pkg::AngW;
  localparam int unsigned Iters    = vav_pkg::CordIters;

  logic [RedW-1:0]        red_d [RedSteps];
  logic [RedW-1:0]        red_q [RedSteps];
  logic signed [AngW-1:0] fold_d, fold_q;
  logic signed [AngW-1:0] quad_d, quad_q;
  logic                   flip_d, flip_q;
  logic signed [AngW-1:0] x_d [Iters];
  logic signed [AngW-1:0] x_q [Iters];
  logic signed [AngW-1:0] y_d [Iters];
  logic signed [AngW-1:0] y_q [Iters];
  logic signed [AngW-1:0] z_d [Iters];
  logic signed [AngW-1:0] z_q [Iters];
  logic                   flp_d [Iters];
  logic                   flp_q [Iters];

  // conditional subtraction of 2*pi multiples, largest first
  always_comb begin
    logic [RedW-1:0] rin;
    logic [RedW-1:0] sub;
    for (int k = 0; k < RedSteps; k++) begin
      if (k == 0) begin
        rin = RedW'(theta_i) << vav_pkg::RedShift;
      end else begin
        rin = red_q[k-1];
      end
      sub      = RedW'(vav_pkg::TwoPiQ61) << (RedSteps - 1 - k);
      red_d[k] = (rin >= sub) ? rin - sub : rin;
    end
  end

  // fold into (-pi, pi] and round to q30
  always_comb begin
    logic [63:0]        rr;
    logic signed [65:0] fold;
    logic signed [65:0] rnd;
    rr = red_q[RedSteps-1][63:0];
    if (rr > (vav_pkg::TwoPiQ61 >> 1)) begin
      fold = $signed({2'b00, rr}) - $signed({2'b00, vav_pkg::TwoPiQ61});
    end else begin
      fold = $signed({2'b00, rr});
    end
    rnd    = fold + (66'sd1 <<< 30);
    fold_d = AngW'(rnd >>> 31);
  end

  // move into [-pi/2, pi/2], remember the sign flip
  always_comb begin
    priority if (fold_q > vav_pkg::HalfPiQ30) begin
      quad_d = fold_q - vav_pkg::PiQ30;
      flip_d = 1'b1;
    end else if (fold_q < -vav_pkg::HalfPiQ30) begin
      quad_d = fold_q + vav_pkg::PiQ30;
      flip_d = 1'b1;
    end else begin
      quad_d = fold_q;
      flip_d = 1'b0;
    end
  end

  // one cordic rotation per stage
  always_comb begin
    logic signed [AngW-1:0] x;
    logic signed [AngW-1:0] y;
    logic signed [AngW-1:0] z;
    logic signed [AngW-1:0] xs;
    logic signed [AngW-1:0] ys;
    logic                   f;
    for (int i = 0; i < Iters; i++) begin
      if (i == 0) begin
        x = vav_pkg::GainQ30;
        y = '0;
        z = quad_q;
        f = flip_q;
      end else begin
        x = x_q[i-1];
        y = y_q[i-1];
        z = z_q[i-1];
        f = flp_q[i-1];
      end
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x_d[i] = x - ys;
        y_d[i] = y + xs;
        z_d[i] = z - vav_pkg::atan_q30(i);
      end else begin
        x_d[i] = x + ys;
        y_d[i] = y - xs;
        z_d[i] = z + vav_pkg::atan_q30(i);
      end
      flp_d[i] = f;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q  <= red_d;
      fold_q <= fold_d;
      quad_q <= quad_d;
      flip_q <= flip_d;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      flp_q  <= flp_d;
    end
  end

  assign cos_o = flp_q[Iters-1] ? -x_q[Iters-1] : x_q[Iters-1];
  assign sin_o = flp_q[Iters-1] ? -y_q[Iters-1] : y_q[Iters-1];

endmodule

>>> hdl/vav_rodrigues.sv
// rodrigues combine: dot, cross, scaled sum, rounding and saturation
module vav_rodrigues (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [vav_pkg::WordW-1:0]  vec_i [3],
  input  logic signed [vav_pkg::WordW-1:0]  unit_i [3],
  input  logic signed [vav_pkg::AngW-1:0]   sin_i,
  input  logic signed [vav_pkg::AngW-1:0]   cos_i,
  input  logic                              zero_i,
  output logic signed [vav_pkg::WordW-1:0]  rot_o [3],
  output logic                              clipped_o
);
  localparam int unsigned WordW = vav_pkg::WordW;
  localparam int unsigned AngW  = vav_pkg::AngW;

  // stage 1
  logic signed [63:0]       uv1_q [3];
  logic signed [63:0]       cp1_q [3];
  logic signed [63:0]       cn1_q [3];
  logic signed [WordW-1:0]  v1_q [3];
  logic signed [WordW-1:0]  u1_q [3];
  logic signed [AngW-1:0]   sn1_q, cs1_q;
  logic                     z1_q;
  // stage 2
  logic signed [33:0]       d2_q;
  logic signed [34:0]       cr2_q [3];
  logic signed [34:0]       omc2_q;
  logic signed [WordW-1:0]  v2_q [3];
  logic signed [WordW-1:0]  u2_q [3];
  logic signed [AngW-1:0]   sn2_q, cs2_q;
  logic                     z2_q;
  // stage 3
  logic signed [68:0]       pd3_q;
  logic signed [65:0]       vc3_q [3];
  logic signed [68:0]       cs3_q [3];
  logic signed [WordW-1:0]  v3_q [3];
  logic signed [WordW-1:0]  u3_q [3];
  logic                     z3_q;
  // stage 4
  logic signed [35:0]       p4_q;
  logic signed [65:0]       vc4_q [3];
  logic signed [68:0]       cs4_q [3];
  logic signed [WordW-1:0]  v4_q [3];
  logic signed [WordW-1:0]  u4_q [3];
  logic                     z4_q;
  // stage 5
  logic signed [67:0]       pu5_q [3];
  logic signed [65:0]       vc5_q [3];
  logic signed [68:0]       cs5_q [3];
  logic signed [WordW-1:0]  v5_q [3];
  logic                     z5_q;
  // stage 6
  logic signed [WordW-1:0]  rot_d [3];
  logic signed [WordW-1:0]  rot_q [3];
  logic                     clip_d, clip_q;

  logic signed [65:0] dot_sum;
  logic signed [33:0] d2_d;
  logic signed [34:0] cr2_d [3];
  logic signed [34:0] omc2_d;
  logic signed [35:0] p4_d;

  // stage 2 and stage 4 rounding
  always_comb begin
    logic signed [64:0] diff;
    logic signed [68:0] pr;
    dot_sum = 66'(uv1_q[0]) + 66'(uv1_q[1]) + 66'(uv1_q[2]) + (66'sd1 <<< 29);
    d2_d    = 34'(dot_sum >>> 30);
    for (int i = 0; i < 3; i++) begin
      diff     = 65'(cp1_q[i]) - 65'(cn1_q[i]) + (65'sd1 <<< 29);
      cr2_d[i] = 35'(diff >>> 30);
    end
    omc2_d = (35'sd1 <<< 30) - 35'(cs1_q);
    pr     = pd3_q + (69'sd1 <<< 29);
    p4_d   = 36'(pr >>> 30);
  end

  // stage 6 sum, rounding and saturation, or the vector passed through for a zero angle
  always_comb begin
    logic signed [69:0] s;
    logic signed [39:0] yv;
    logic               fits;
    clip_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s    = 70'(pu5_q[i]) + 70'(vc5_q[i]) + 70'(cs5_q[i]) + (70'sd1 <<< 29);
      yv   = 40'(s >>> 30);
      fits = (yv[39:WordW-1] == '0) || (yv[39:WordW-1] == '1);
      if (z5_q) begin
        rot_d[i] = v5_q[i];
      end else if (fits) begin
        rot_d[i] = yv[WordW-1:0];
      end else begin
        rot_d[i] = yv[39] ? vav_pkg::WordMin : vav_pkg::WordMax;
        clip_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // products of unit axis and vector
      for (int i = 0; i < 3; i++) begin
        uv1_q[i] <= 64'(unit_i[i]) * 64'(vec_i[i]);
        cp1_q[i] <= 64'(unit_i[(i == 2) ? 0 : i + 1]) * 64'(vec_i[(i == 0) ? 2 : i - 1]);
        cn1_q[i] <= 64'(unit_i[(i == 0) ? 2 : i - 1]) * 64'(vec_i[(i == 2) ? 0 : i + 1]);
      end
      v1_q  <= vec_i;
      u1_q  <= unit_i;
      sn1_q <= sin_i;
      cs1_q <= cos_i;
      z1_q  <= zero_i;
      // dot, cross, one minus cosine
      d2_q   <= d2_d;
      cr2_q  <= cr2_d;
      omc2_q <= omc2_d;
      v2_q   <= v1_q;
      u2_q   <= u1_q;
      sn2_q  <= sn1_q;
      cs2_q  <= cs1_q;
      z2_q   <= z1_q;
      // scaling products
      pd3_q <= 69'(d2_q) * 69'(omc2_q);
      for (int i = 0; i < 3; i++) begin
        vc3_q[i] <= 66'(v2_q[i]) * 66'(cs2_q);
        cs3_q[i] <= 69'(cr2_q[i]) * 69'(sn2_q);
      end
      v3_q <= v2_q;
      u3_q <= u2_q;
      z3_q <= z2_q;
      // rounded parallel factor
      p4_q  <= p4_d;
      vc4_q <= vc3_q;
      cs4_q <= cs3_q;
      v4_q  <= v3_q;
      u4_q  <= u3_q;
      z4_q  <= z3_q;
      // parallel component
      for (int i = 0; i < 3; i++) begin
        pu5_q[i] <= 68'(p4_q) * 68'(u4_q[i]);
      end
      vc5_q <= vc4_q;
      cs5_q <= cs4_q;
      v5_q  <= v4_q;
      z5_q  <= z4_q;
      // result
      rot_q  <= rot_d;
      clip_q <= clip_d;
    end
  end

  assign rot_o     = rot_q;
  assign clipped_o = clip_q;

endmodule

>>> hdl/vav_checker.sv
// port-level checker for the rotation pipeline, bound to the top level
`include "assert_macros.svh"

module vav_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic signed [vav_pkg::WordW-1:0]  rot_x_o,
  input  logic signed [vav_pkg::WordW-1:0]  rot_y_o,
  input  logic signed [vav_pkg::WordW-1:0]  rot_z_o,
  input  logic                              clipped_o
);

  // held output beat stays valid
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // held output beat keeps its payload
  `ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(rot_x_o) && $stable(rot_y_o) && $stable(rot_z_o) && $stable(clipped_o))

  // input side only stalls behind a held output beat
  `ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // a clipped beat has a component sitting on a bound
  `ASSERT_IMP(a_clip_bound, clk_i, rst_ni, out_valid_o && clipped_o, rot_x_o == vav_pkg::WordMax || rot_x_o == vav_pkg::WordMin || rot_y_o == vav_pkg::WordMax || rot_y_o == vav_pkg::WordMin || rot_z_o == vav_pkg::WordMax || rot_z_o == vav_pkg::WordMin)

endmodule

bind axis_angle_vector_rotate vav_checker u_vav_checker (.*);

>>> tb/tb.sv
// self-checking testbench of the axis-angle vector rotation pipeline
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = vav_pkg::WordW;
  localparam logic [63:0] TwoPi = 64'hC90FDAA22168C235;
  localparam int unsigned RandItems = 1750;
  localparam int unsigned DrainCycles = 120;

  typedef logic signed [W-1:0] word_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    word_t x, y, z;
    logic  clip;
  } rot_t;

  typedef struct {
    word_t vx, vy, vz, ax, ay, az;
    logic  typed;
    rot_t  res;
  } row_t;

  logic  clk, rst_n;
  logic  in_valid, in_stall, out_valid, out_stall, clipped;
  word_t vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, rot_x, rot_y, rot_z;

  rot_t rot_q[$];
  int   fails = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_cycles = 0;

  axis_angle_vector_rotate dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .vec_x_i(vec_x), .vec_y_i(vec_y), .vec_z_i(vec_z),
    .axis_x_i(axis_x), .axis_y_i(axis_y), .axis_z_i(axis_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .rot_x_o(rot_x), .rot_y_o(rot_y), .rot_z_o(rot_z), .clipped_o(clipped)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  // round half up, dropping 30 fraction bits
  function automatic wide_t round_q30(input wide_t val);
    return (val + (128'sd1 <<< 29)) >>> 30;
  endfunction

  // atan(2^-i) in q30 from pi/4 for i = 0, else from its taylor series in q60
  function automatic wide_t atan_step(input int i);
    wide_t acc;
    wide_t term;
    acc = 0;
    if (i == 0) begin
      acc = $signed({64'd0, TwoPi >> 4});
    end else begin
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        term = (128'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
        acc = (k % 2 == 1) ? acc - term : acc + term;
      end
    end
    return (acc + (128'sd1 <<< 29)) >>> 30;
  endfunction

  // rodrigues rotation of one beat, bit exact
  function automatic rot_t rotate_vec(input word_t vx, vy, vz, ax, ay, az);
    rot_t        r;
    wide_t       vw[3], aw[3], uw[3];
    wide_t       ang, half, pi30, cx, cy, xs, ys, cs, sn, d, p, cr, yv, lim_hi, lim_lo;
    logic [127:0] ss, c, q, rr, mag[3];
    logic [63:0] root;
    logic        flip;
    word_t       outs[3];
    int          j, k;
    vw[0] = vx; vw[1] = vy; vw[2] = vz;
    aw[0] = ax; aw[1] = ay; aw[2] = az;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (aw[i] < 0) ? -aw[i] : aw[i];
      ss += mag[i] * mag[i];
    end
    // integer square root
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'd0, root | (64'd1 << b)};
      if (c * c <= ss) root = c[63:0];
    end
    r.clip = 1'b0;
    if (root == 0) begin
      r.x = vx; r.y = vy; r.z = vz;
      return r;
    end
    // unit axis, truncated
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << 30) / {64'd0, root};
      uw[i] = (aw[i] < 0) ? -$signed(q) : $signed(q);
    end
    // angle reduction into +-pi/2
    rr = ({64'd0, root} << (61 - vav_pkg::FracBits)) % {64'd0, TwoPi};
    if (rr > {64'd0, TwoPi >> 1}) ang = -$signed({64'd0, TwoPi} - rr);
    else ang = $signed(rr);
    ang = (ang + (128'sd1 <<< 30)) >>> 31;
    pi30 = $signed(({64'd0, TwoPi} + (128'd1 << 31)) >> 32);
    half = $signed(({64'd0, TwoPi} + (128'd1 << 32)) >> 33);
    flip = 1'b0;
    if (ang > half) begin
      ang -= pi30; flip = 1'b1;
    end else if (ang < -half) begin
      ang += pi30; flip = 1'b1;
    end
    // cordic rotation
    cx = 128'sd652032874;
    cy = 0;
    for (int i = 0; i < 30; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (ang >= 0) begin
        cx -= ys; cy += xs; ang -= atan_step(i);
      end else begin
        cx += ys; cy -= xs; ang += atan_step(i);
      end
    end
    cs = flip ? -cx : cx;
    sn = flip ? -cy : cy;
    // combine
    d = round_q30(uw[0] * vw[0] + uw[1] * vw[1] + uw[2] * vw[2]);
    p = round_q30(d * ((128'sd1 <<< 30) - cs));
    lim_hi = (128'sd1 <<< (W - 1)) - 1;
    lim_lo = -(128'sd1 <<< (W - 1));
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      cr = round_q30(uw[j] * vw[k] - uw[k] * vw[j]);
      yv = round_q30(p * uw[i] + vw[i] * cs + cr * sn);
      if (yv > lim_hi) begin
        outs[i] = vav_pkg::WordMax; r.clip = 1'b1;
      end else if (yv < lim_lo) begin
        outs[i] = vav_pkg::WordMin; r.clip = 1'b1;
      end else begin
        outs[i] = yv[W-1:0];
      end
    end
    r.x = outs[0]; r.y = outs[1]; r.z = outs[2];
    return r;
  endfunction

  // offer one beat and wait until it is taken
  task automatic send_beat(input word_t vx, vy, vz, ax, ay, az, input logic typed,
                           input rot_t res);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    vec_x = vx; vec_y = vy; vec_z = vz;
    axis_x = ax; axis_y = ay; axis_z = az;
    do @(posedge clk); while (in_stall);
    rot_q.push_back(typed ? res : rotate_vec(vx, vy, vz, ax, ay, az));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic word_t rand_word(input int mode);
    case (mode)
      0: return $signed($urandom);
      1: return $signed($urandom_range(8 << 16)) - (4 << 16);
      default: return $signed($urandom_range(2 << 16)) - (1 << 16);
    endcase
  endfunction

  // receiver side stall
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // output beat checker
  always @(posedge clk) begin
    rot_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rot_q.size() == 0) begin
        $error("output beat with nothing expected");
        fails++;
      end else begin
        e = rot_q.pop_front();
        if (rot_x !== e.x) begin
          $error("rot_x expected %0d actual %0d", e.x, rot_x); fails++;
        end
        if (rot_y !== e.y) begin
          $error("rot_y expected %0d actual %0d", e.y, rot_y); fails++;
        end
        if (rot_z !== e.z) begin
          $error("rot_z expected %0d actual %0d", e.z, rot_z); fails++;
        end
        if (clipped !== e.clip) begin
          $error("clipped expected %0b actual %0b", e.clip, clipped); fails++;
        end
      end
    end
  end

  // stimulus
  initial begin
    row_t  rows[$];
    row_t  rw;
    rot_t  none;
    word_t mx, mn, one;
    int    vm, am;
    mx = vav_pkg::WordMax;
    mn = vav_pkg::WordMin;
    one = 1 << 16;
    none = '{0, 0, 0, 1'b0};
    in_valid = 1'b0;
    out_stall = 1'b0;
    vec_x = 0; vec_y = 0; vec_z = 0;
    axis_x = 0; axis_y = 0; axis_z = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows: zero rotation passes through, the rest predicted
    rows.push_back('{0, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 0, 1'b0}});
    rows.push_back('{mx, mx, mx, 0, 0, 0, 1'b1, '{mx, mx, mx, 1'b0}});
    rows.push_back('{mn, mn, mn, 0, 0, 0, 1'b1, '{mn, mn, mn, 1'b0}});
    rows.push_back('{mx, mn, -1, 0, 0, 0, 1'b1, '{mx, mn, -1, 1'b0}});
    rows.push_back('{one, 0, 0, 0, 0, 1, 1'b0, none});
    rows.push_back('{one, 0, 0, 0, 0, 102944, 1'b0, none});
    rows.push_back('{one, 2 * one, 3 * one, 205887, 0, 0, 1'b0, none});
    rows.push_back('{one, one, one, 0, 0, -102944, 1'b0, none});
    rows.push_back('{mx, mx, 0, 0, 0, 51472, 1'b0, none});
    rows.push_back('{mn, mn, 0, 0, 0, 51472, 1'b0, none});
    rows.push_back('{mx, mx, mx, one, one, one, 1'b0, none});
    rows.push_back('{mn, mx, mn, -one, one, -one, 1'b0, none});
    rows.push_back('{one, one, one, mx, mx, mx, 1'b0, none});
    rows.push_back('{one, -one, one, mn, mn, mn, 1'b0, none});
    rows.push_back('{-one, one, 0, mx, 0, 0, 1'b0, none});
    rows.push_back('{one, one, 0, 0, mn, 0, 1'b0, none});
    rows.push_back('{one, 0, one, 411775, 0, 0, 1'b0, none});
    rows.push_back('{one, 0, one, 0, 308831, 0, 1'b0, none});
    rows.push_back('{mx, 0, 0, 0, 0, 411775, 1'b0, none});
    rows.push_back('{-1, -1, -1, 1, 1, 1, 1'b0, none});
    rows.push_back('{12345, -6789, 999, -one, 3 * one, 2 * one, 1'b0, none});
    foreach (rows[i]) begin
      rw = rows[i];
      send_beat(rw.vx, rw.vy, rw.vz, rw.ax, rw.ay, rw.az, rw.typed, rw.res);
    end

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 66 : (ph == 3) ? 30 : 0;
      stall_pct = (ph == 2) ? 66 : (ph == 3) ? 30 : 0;
      // long receiver hold-off so the pipeline backs up into the input
      if (ph == 0) hold_cycles = 300;
      for (int n = 0; n < RandItems / 4; n++) begin
        vm = ($urandom_range(9) < 3) ? 0 : 1;
        am = $urandom_range(9);
        if (am == 0) begin
          send_beat(rand_word(vm), rand_word(vm), rand_word(vm), 0, 0, 0, 1'b0, none);
        end else begin
          am = (am < 3) ? 0 : (am < 7) ? 1 : 2;
          send_beat(rand_word(vm), rand_word(vm), rand_word(vm),
                    rand_word(am), rand_word(am), rand_word(am), 1'b0, none);
        end
      end
      // sender pauses until the pipeline has drained
      while (rot_q.size() != 0) @(negedge clk);
    end

    stall_pct = 0;
    repeat (DrainCycles) @(negedge clk);
    if (fails == 0 && rot_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
